### sv/tcce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cell engine
// Command layout, microcode words and the sequencer program.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ATTR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_GLYPH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PRN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_PRN     = 3'd6;

    // register reset values
    localparam logic [4:0] TOP_ROW_RST      = 5'd0;
    localparam logic [7:0] TEXT_ATTR_RST    = 8'h02;
    localparam logic [7:0] CURSOR_ATTR_RST  = 8'h33;
    localparam logic [7:0] CURSOR_GLYPH_RST = 8'h5F;
    localparam logic       CURSOR_ON_RST    = 1'b1;
    localparam logic [7:0] FIRST_PRN_RST    = 8'h20;
    localparam logic [7:0] LAST_PRN_RST     = 8'h7E;

    // character codes and store fill
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] ATTR_RESET = 8'h02;

    // item and command kinds
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_MOVE = 1'b1;
    localparam logic K_CELL  = 1'b0;
    localparam logic K_ROW   = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           glyph;
        logic [7:0]           attr;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
    } t_cmd;

    // datapath operations, one per microcode step
    typedef enum logic [3:0] {
        U_INIT,
        U_IDLE,
        U_RESTORE,
        U_PUT,
        U_CURSOR,
        U_CLR_SET,
        U_CLR_WALK,
        U_CLR_EMIT,
        U_FINISH,
        U_MOVE
    } t_uop;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_INIT_MORE,
        C_NO_ITEM,
        C_IS_MOVE,
        C_NO_CLEAR,
        C_WALK_MORE,
        C_FIRST_PASS
    } t_cond;

    typedef logic [3:0] t_upc;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_upc  target;
    } t_ctl;

    localparam t_upc S_INIT     = 4'd0;
    localparam t_upc S_IDLE     = 4'd1;
    localparam t_upc S_RESTORE  = 4'd2;
    localparam t_upc S_PUT      = 4'd3;
    localparam t_upc S_CURS     = 4'd4;
    localparam t_upc S_CLR_SET  = 4'd5;
    localparam t_upc S_CLR_WALK = 4'd6;
    localparam t_upc S_CLR_EMIT = 4'd7;
    localparam t_upc S_FIN      = 4'd8;
    localparam t_upc S_MOVE     = 4'd9;
    localparam t_upc S_MCURS    = 4'd10;

    // the program: jump to target when the condition holds, else fall through
    function automatic t_ctl ucode(input t_upc a);
        t_ctl c;
        case (a)
            S_INIT:     c = '{U_INIT,     C_INIT_MORE,  S_INIT};
            S_IDLE:     c = '{U_IDLE,     C_NO_ITEM,    S_IDLE};
            S_RESTORE:  c = '{U_RESTORE,  C_IS_MOVE,    S_MOVE};
            S_PUT:      c = '{U_PUT,      C_NEVER,      S_IDLE};
            S_CURS:     c = '{U_CURSOR,   C_NO_CLEAR,   S_FIN};
            S_CLR_SET:  c = '{U_CLR_SET,  C_NEVER,      S_IDLE};
            S_CLR_WALK: c = '{U_CLR_WALK, C_WALK_MORE,  S_CLR_WALK};
            S_CLR_EMIT: c = '{U_CLR_EMIT, C_FIRST_PASS, S_CLR_WALK};
            S_FIN:      c = '{U_FINISH,   C_ALWAYS,     S_IDLE};
            S_MOVE:     c = '{U_MOVE,     C_NEVER,      S_IDLE};
            S_MCURS:    c = '{U_CURSOR,   C_ALWAYS,     S_FIN};
            default:    c = '{U_IDLE,     C_ALWAYS,     S_IDLE};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### sv/text_console_cell_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_engine_unit: text console cursor and cell store engine
// Microcoded sequencer over a character/attribute store and a cursor.
// ----------------------------------------------------------------------------
// The engine keeps a character and attribute store for a ROWS by COLS text
// grid plus the cursor position, and turns each input transaction (put
// character or move cursor) into a short run of draw-cell and clear-row
// commands, the final one flagged with tlast. After reset a clearing pass
// fills the store with spaces and attribute 0x02, and no item is taken
// meanwhile (configuration writes still are). A move, or a put that keeps
// the cursor on its line, runs to its end before the next item is taken.
// A put that changes line also clears two rows; each row clear walks the
// store one cell per cycle over its single write port. A slow consumer
// can stall the sequencer, since one pending command and one output
// register sit between the sequencer and the master side.
// ----------------------------------------------------------------------------
module text_console_cell_engine_unit #(
    parameter int COLS         = 80,
    parameter int ROWS         = 30,
    parameter int VISIBLE_COLS = 80
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side, tdata: char_code, target_col, target_row; tuser: op
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tcce_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,
    // master side, tdata: glyph, attr_byte, col, row, zero pad; tuser: kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tcce_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tuser,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tcce_pkg::*;

    // geometry
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int RWX   = RW + 1;
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0]     COLS_A    = AW'(COLS);
    localparam logic [AW-1:0]     LAST_CELL = AW'(CELLS - 1);
    localparam logic [CW-1:0]     COL_MAX   = CW'(COLS - 1);
    localparam logic [RW-1:0]     ROW_MAX   = RW'(ROWS - 1);
    localparam logic [RW:0]       ROWS_X    = RWX'(ROWS);
    localparam logic [6:0]        ROWS_7    = 7'(ROWS);
    localparam logic [7:0]        VIS_LIM   = 8'(VISIBLE_COLS);
    localparam logic signed [8:0] COLS_S    = 9'(COLS);
    localparam logic signed [8:0] ROWS_S    = 9'(ROWS);

    // configuration registers
    logic [4:0] r_top;
    logic [7:0] r_tattr;
    logic [7:0] r_cattr;
    logic [7:0] r_cglyph;
    logic       r_con;
    logic [7:0] r_fp;
    logic [7:0] r_lp;

    // sequencer
    t_upc r_upc;
    t_upc n_upc;
    t_ctl w_ctl;
    logic w_jump;
    logic w_hold;
    logic w_go;

    // latched item
    logic       r_op;
    logic [7:0] r_code;
    logic [7:0] r_tcol;
    logic [7:0] r_trow;
    logic       w_accept;

    // cursor and clear walk
    logic [CW-1:0] r_ccol;
    logic [CW-1:0] n_ccol;
    logic [RW-1:0] r_crow;
    logic [RW-1:0] n_crow;
    logic          r_need_clr;
    logic          n_need_clr;
    logic          r_pass;
    logic [RW-1:0] r_clr_row;
    logic [AW-1:0] r_wcnt;

    // store
    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rd;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_cur_addr;
    logic [AW-1:0] w_clr_addr;

    // command path
    t_cmd w_cand;
    logic w_cand_v;
    t_cmd r_pnd;
    logic r_pnd_v;
    t_cmd r_out;
    logic r_out_last;
    logic r_out_v;
    logic w_out_free;
    logic w_out_load;

    // datapath helpers
    logic [RW-1:0]     w_etop;
    logic              w_vis;
    logic              w_is_nl;
    logic              w_is_cr;
    logic              w_is_bs;
    logic              w_is_prn;
    logic [7:0]        w_code_m;
    logic [RW:0]       w_row_inc;
    logic [RW-1:0]     w_row_next;
    logic [RW:0]       w_clr_inc;
    logic [RW-1:0]     w_clr_next;
    logic signed [8:0] w_x9;
    logic signed [8:0] w_y9;
    logic signed [8:0] w_top9;
    logic [CW-1:0]     w_mv_col;
    logic [RW-1:0]     w_mv_row;

    assign w_ctl         = ucode(r_upc);
    assign s_axis_tready = (w_ctl.uop == U_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    // a top row past the grid behaves as the bottom row
    assign w_etop = ({2'b00, r_top} >= ROWS_7) ? ROW_MAX : RW'(r_top);

    assign w_cur_addr = AW'(r_crow) * COLS_A + AW'(r_ccol);
    assign w_clr_addr = AW'(r_clr_row) * COLS_A + AW'(r_wcnt[CW-1:0]);

    // cells past the visible width are stored but never drawn
    assign w_vis = (8'(r_ccol) < VIS_LIM);

    assign w_is_nl  = (r_code == CH_NL);
    assign w_is_cr  = (r_code == CH_CR);
    assign w_is_bs  = (r_code == CH_BS);
    assign w_is_prn = !(w_is_nl || w_is_cr || w_is_bs);

    // codes outside the font become a dot (also when the range is empty)
    assign w_code_m = (r_code < r_fp || r_code > r_lp) ? CH_DOT : r_code;

    // next line, wrapping back to the top text row
    assign w_row_inc  = {1'b0, r_crow} + RWX'(1);
    assign w_row_next = (w_row_inc == ROWS_X) ? w_etop : w_row_inc[RW-1:0];
    assign w_clr_inc  = {1'b0, r_clr_row} + RWX'(1);
    assign w_clr_next = (w_clr_inc == ROWS_X) ? w_etop : w_clr_inc[RW-1:0];

    // move target clamp
    assign w_x9   = $signed({r_tcol[7], r_tcol});
    assign w_y9   = $signed({r_trow[7], r_trow});
    assign w_top9 = $signed(9'(w_etop));

    always_comb begin
        if (w_x9 < 9'sd0) begin
            w_mv_col = '0;
        end else if (w_x9 >= COLS_S) begin
            w_mv_col = COL_MAX;
        end else begin
            w_mv_col = CW'(r_tcol);
        end
        if (w_y9 < w_top9) begin
            w_mv_row = w_etop;
        end else if (w_y9 >= ROWS_S) begin
            w_mv_row = ROW_MAX;
        end else begin
            w_mv_row = RW'(r_trow);
        end
    end

    // candidate command of the current step
    always_comb begin
        w_cand   = '{K_CELL, CH_SPACE, r_tattr, 7'(r_ccol), 5'(r_crow)};
        w_cand_v = 1'b0;
        case (w_ctl.uop)
            U_RESTORE: begin
                w_cand   = '{K_CELL, r_rd[15:8], r_rd[7:0], 7'(r_ccol), 5'(r_crow)};
                w_cand_v = r_con & w_vis;
            end
            U_PUT: begin
                w_cand   = '{K_CELL, w_code_m, r_tattr, 7'(r_ccol), 5'(r_crow)};
                w_cand_v = w_is_prn & w_vis;
            end
            U_CURSOR: begin
                w_cand   = '{K_CELL, r_cglyph, r_cattr, 7'(r_ccol), 5'(r_crow)};
                w_cand_v = r_con & w_vis;
            end
            U_CLR_EMIT: begin
                w_cand   = '{K_ROW, CH_SPACE, r_tattr, '0, 5'(r_clr_row)};
                w_cand_v = 1'b1;
            end
            default: begin
                w_cand_v = 1'b0;
            end
        endcase
    end

    // a new command pushes the pending one out; the finish step flushes it
    // with the last flag, so the flag always lands on the final command
    assign w_out_free = !r_out_v || m_axis_tready;
    assign w_hold     = (w_cand_v || w_ctl.uop == U_FINISH) && r_pnd_v && !w_out_free;
    assign w_go       = !w_hold;
    assign w_out_load = w_go && r_pnd_v && (w_cand_v || w_ctl.uop == U_FINISH);

    // jump condition
    always_comb begin
        case (w_ctl.cond)
            C_NEVER:      w_jump = 1'b0;
            C_ALWAYS:     w_jump = 1'b1;
            C_INIT_MORE:  w_jump = (r_wcnt != LAST_CELL);
            C_NO_ITEM:    w_jump = !w_accept;
            C_IS_MOVE:    w_jump = (r_op == OP_MOVE);
            C_NO_CLEAR:   w_jump = !r_need_clr;
            C_WALK_MORE:  w_jump = (r_wcnt[CW-1:0] != COL_MAX);
            C_FIRST_PASS: w_jump = !r_pass;
            default:      w_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (w_hold) begin
            n_upc = r_upc;
        end else if (w_jump) begin
            n_upc = w_ctl.target;
        end else begin
            n_upc = r_upc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_INIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    // cursor update for put and move
    always_comb begin
        n_ccol     = r_ccol;
        n_crow     = r_crow;
        n_need_clr = r_need_clr;
        if (w_go && w_ctl.uop == U_PUT) begin
            n_need_clr = 1'b0;
            if (w_is_nl) begin
                n_ccol     = '0;
                n_crow     = w_row_next;
                n_need_clr = 1'b1;
            end else if (w_is_cr) begin
                n_ccol = '0;
            end else if (w_is_bs) begin
                // backspace at line start goes to the end of the row above (on row 0, to the end of row 0)
                if (r_ccol == '0) begin
                    n_ccol = COL_MAX;
                    if (r_crow != '0) begin
                        n_crow = r_crow - RW'(1);
                    end
                end else begin
                    n_ccol = r_ccol - CW'(1);
                end
            end else if (r_ccol == COL_MAX) begin
                n_ccol     = '0;
                n_crow     = w_row_next;
                n_need_clr = 1'b1;
            end else begin
                n_ccol = r_ccol + CW'(1);
            end
        end else if (w_go && w_ctl.uop == U_MOVE) begin
            n_ccol = w_mv_col;
            n_crow = w_mv_row;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= TOP_ROW_RST;
            r_tattr    <= TEXT_ATTR_RST;
            r_cattr    <= CURSOR_ATTR_RST;
            r_cglyph   <= CURSOR_GLYPH_RST;
            r_con      <= CURSOR_ON_RST;
            r_fp       <= FIRST_PRN_RST;
            r_lp       <= LAST_PRN_RST;
            r_ccol     <= '0;
            r_crow     <= '0;
            r_need_clr <= 1'b0;
            r_pass     <= 1'b0;
            r_wcnt     <= '0;
            r_pnd_v    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOP_ROW:      r_top    <= i_cfg_data[4:0];
                    CFG_TEXT_ATTR:    r_tattr  <= i_cfg_data;
                    CFG_CURSOR_ATTR:  r_cattr  <= i_cfg_data;
                    CFG_CURSOR_GLYPH: r_cglyph <= i_cfg_data;
                    CFG_CURSOR_ON:    r_con    <= i_cfg_data[0];
                    CFG_FIRST_PRN:    r_fp     <= i_cfg_data;
                    CFG_LAST_PRN:     r_lp     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            r_ccol     <= n_ccol;
            r_crow     <= n_crow;
            r_need_clr <= n_need_clr;

            if (w_go) begin
                case (w_ctl.uop)
                    U_INIT:     r_wcnt <= r_wcnt + AW'(1);
                    U_CLR_SET: begin
                        r_wcnt <= '0;
                        r_pass <= 1'b0;
                    end
                    U_CLR_WALK: r_wcnt <= r_wcnt + AW'(1);
                    U_CLR_EMIT: begin
                        r_wcnt <= '0;
                        r_pass <= 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (w_cand_v) begin
                    r_pnd_v <= 1'b1;
                end else if (w_ctl.uop == U_FINISH) begin
                    r_pnd_v <= 1'b0;
                end
            end

            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_code <= s_axis_tdata[7:0];
            r_tcol <= s_axis_tdata[15:8];
            r_trow <= s_axis_tdata[23:16];
        end
        if (w_go && w_ctl.uop == U_CLR_SET) begin
            r_clr_row <= w_row_next;
        end else if (w_go && w_ctl.uop == U_CLR_EMIT) begin
            r_clr_row <= w_clr_next;
        end
        if (w_go && w_cand_v) begin
            r_pnd <= w_cand;
        end
        if (w_out_load) begin
            r_out      <= r_pnd;
            r_out_last <= (w_ctl.uop == U_FINISH);
        end
    end

    // store write: reset fill, character cell, or row clear walk
    always_comb begin
        w_we = w_go && (w_ctl.uop == U_INIT || w_ctl.uop == U_CLR_WALK
                        || (w_ctl.uop == U_PUT && w_is_prn));
        if (w_ctl.uop == U_INIT) begin
            w_waddr = r_wcnt;
            w_wdata = {CH_SPACE, ATTR_RESET};
        end else if (w_ctl.uop == U_PUT) begin
            w_waddr = w_cur_addr;
            w_wdata = {w_code_m, r_tattr};
        end else begin
            w_waddr = w_clr_addr;
            w_wdata = {CH_SPACE, r_tattr};
        end
    end

    // cursor cell is read every cycle; it is stable while waiting for an item
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_cur_addr];
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {4'b0000, r_out.row, r_out.col, r_out.attr, r_out.glyph};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out_last;

    // the output register is only loaded when its transaction has gone
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("output command overwritten before transfer");

    // cursor stays on the grid once the store is filled
    a_cursor_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc != S_INIT) |-> (r_ccol <= COL_MAX && r_crow <= ROW_MAX))
        else $error("cursor left the grid");

    // no command is left pending when a new item may be taken
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.uop == U_IDLE) |-> !r_pnd_v)
        else $error("pending command not flushed at item end");

endmodule
`default_nettype wire
